### rtl/dll_pkg.sv
// Shared types and codes for the linked list manager.
// No dependencies.
`default_nettype none
package dll_pkg;
    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK = 3'd1,
        REQ_POP_FRONT = 3'd2,
        REQ_POP_BACK = 3'd3,
        REQ_INS_AFTER = 3'd4,
        REQ_INS_BEFORE = 3'd5,
        REQ_REMOVE = 3'd6,
        REQ_NONE = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_START_WALK,
        OP_RD_CUR,
        OP_CHECK,
        OP_TAKE,
        OP_LINK_NEW,
        OP_LINK_P,
        OP_LINK_Q,
        OP_RD_AT,
        OP_UNLINK_P,
        OP_UNLINK_Q,
        OP_GIVE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic head_null;
        logic at_null;
        logic match;
        logic walk_done;
        logic pool_empty;
    } stat_t;
endpackage
`default_nettype wire

### rtl/dll_datapath.sv
// Datapath of the linked list manager: node memories, free pool and links.
// Depends on dll_pkg.
`default_nettype none
module dll_datapath #(
    parameter int CAPACITY = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int IW = $clog2(CAPACITY + 1)
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire dll_pkg::cmd_t cmd,
    input wire logic [2:0] req_type,
    input wire logic [31:0] data_value,
    input wire logic [31:0] search_key,
    output dll_pkg::stat_t stat,
    output logic [31:0] popped_value,
    output logic list_empty
);
    import dll_pkg::*;
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
    logic [IW-1:0] next_mem [CAPACITY];
    logic [IW-1:0] prev_mem [CAPACITY];
    logic [AW-1:0] free_mem [CAPACITY];

    logic [IW-1:0] head_reg, tail_reg, free_cnt_reg, fill_reg;
    logic [IW-1:0] cur_reg, at_reg, n_reg, p_reg, q_reg, steps_reg;
    logic [VALUE_WIDTH-1:0] val_reg, key_reg, rd_val_reg;
    logic [IW-1:0] rd_next_reg, rd_prev_reg;
    logic [AW-1:0] free_rd_reg;
    logic [2:0] req_reg;
    logic [31:0] popped_reg;

    function automatic logic [VALUE_WIDTH-1:0] vfit(input logic [31:0] x);
        logic [63:0] s;
        s = {{32{x[31]}}, x};
        return s[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] vout(input logic [VALUE_WIDTH-1:0] x);
        logic [63:0] s;
        s = 64'(x);
        return s[31:0];
    endfunction

    // The free stack is filled lazily: entries below the lowest count ever reached
    // still hold their reset slot; entries at or above it have been written.
    logic [IW-1:0] top_idx;
    logic top_from_mem;
    assign top_idx = free_cnt_reg - IW'(1);
    assign top_from_mem = top_idx >= fill_reg;

    logic is_search;
    assign is_search = (req_reg == REQ_INS_AFTER) || (req_reg == REQ_INS_BEFORE)
        || (req_reg == REQ_REMOVE);
    logic [VALUE_WIDTH-1:0] target;
    assign target = (req_reg == REQ_REMOVE) ? val_reg : key_reg;

    assign stat.head_null = head_reg == NIL;
    assign stat.at_null = (((req_reg == REQ_POP_FRONT) ? head_reg : tail_reg) == NIL);
    assign stat.match = rd_val_reg == target;
    assign stat.walk_done = (rd_next_reg >= NIL) || (steps_reg >= NIL - IW'(1));
    assign stat.pool_empty = free_cnt_reg == '0;
    assign popped_value = popped_reg;
    assign list_empty = head_reg == NIL;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_RD_CUR, OP_RD_AT:
            begin
                rd_val_reg <= val_mem[cur_reg[AW-1:0]];
                rd_next_reg <= next_mem[cur_reg[AW-1:0]];
                rd_prev_reg <= prev_mem[cur_reg[AW-1:0]];
            end
            OP_LINK_NEW:
            begin
                val_mem[n_reg[AW-1:0]] <= val_reg;
                prev_mem[n_reg[AW-1:0]] <= p_reg;
                next_mem[n_reg[AW-1:0]] <= q_reg;
            end
            OP_LINK_P, OP_UNLINK_P:
                if (p_reg != NIL)
                    next_mem[p_reg[AW-1:0]] <= (cmd.op == OP_LINK_P) ? n_reg : q_reg;
            OP_LINK_Q, OP_UNLINK_Q:
                if (q_reg != NIL)
                    prev_mem[q_reg[AW-1:0]] <= (cmd.op == OP_LINK_Q) ? n_reg : p_reg;
            OP_GIVE:
                free_mem[free_cnt_reg[AW-1:0]] <= at_reg[AW-1:0];
            default:
                free_rd_reg <= free_mem[top_idx[AW-1:0]];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NIL;
            tail_reg <= NIL;
            free_cnt_reg <= NIL;
            fill_reg <= NIL;
            popped_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    req_reg <= req_type;
                    val_reg <= vfit(data_value);
                    key_reg <= vfit(search_key);
                    popped_reg <= '0;
                end
                OP_START_WALK:
                begin
                    cur_reg <= (req_reg == REQ_POP_BACK) ? tail_reg : head_reg;
                    steps_reg <= '0;
                end
                OP_CHECK:
                begin
                    if (is_search)
                    begin
                        at_reg <= cur_reg;
                        cur_reg <= rd_next_reg;
                        steps_reg <= steps_reg + IW'(1);
                    end
                    else
                    begin
                        at_reg <= cur_reg;
                        popped_reg <= vout(rd_val_reg);
                    end
                    if (req_reg == REQ_INS_AFTER)
                    begin
                        p_reg <= cur_reg;
                        q_reg <= rd_next_reg;
                    end
                    else
                    begin
                        p_reg <= rd_prev_reg;
                        q_reg <= (req_reg == REQ_INS_BEFORE) ? cur_reg : rd_next_reg;
                    end
                end
                OP_TAKE:
                begin
                    n_reg <= top_from_mem ? IW'(free_rd_reg)
                                          : IW'(CAPACITY) - IW'(1) - top_idx;
                    free_cnt_reg <= top_idx;
                    if (top_idx < fill_reg)
                        fill_reg <= top_idx;
                    if (req_reg == REQ_PUSH_FRONT)
                    begin
                        p_reg <= NIL;
                        q_reg <= head_reg;
                    end
                    else if (req_reg == REQ_PUSH_BACK)
                    begin
                        p_reg <= tail_reg;
                        q_reg <= NIL;
                    end
                end
                OP_LINK_P:
                    if (p_reg == NIL)
                        head_reg <= n_reg;
                OP_LINK_Q:
                    if (q_reg == NIL)
                        tail_reg <= n_reg;
                OP_UNLINK_P:
                    if (p_reg == NIL)
                        head_reg <= q_reg;
                OP_UNLINK_Q:
                    if (q_reg == NIL)
                        tail_reg <= p_reg;
                OP_GIVE:
                    free_cnt_reg <= free_cnt_reg + IW'(1);
                default:
                    ;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/dll_ctrl.sv
// Controller state machine of the linked list manager.
// Depends on dll_pkg.
`default_nettype none
module dll_ctrl (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [2:0] req_type,
    output logic out_valid,
    input wire logic out_ready,
    output logic [1:0] status,
    output dll_pkg::cmd_t cmd,
    input wire dll_pkg::stat_t stat
);
    import dll_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_WALK, S_READ, S_CHECK, S_TAKE, S_LINK_NEW,
        S_LINK_P, S_LINK_Q, S_UNLINK_P, S_UNLINK_Q, S_GIVE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic [2:0] req_reg;
    logic is_pop, is_push;

    assign is_pop = (req_reg == REQ_POP_FRONT) || (req_reg == REQ_POP_BACK);
    assign is_push = (req_reg == REQ_PUSH_FRONT) || (req_reg == REQ_PUSH_BACK);
    assign in_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign status = status_reg;

    always_comb
    begin
        state_next = state_reg;
        status_next = status_reg;
        cmd.op = OP_IDLE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    status_next = ST_DONE;
                    state_next = S_DISPATCH;
                end
            S_DISPATCH:
                if (is_push)
                begin
                    if (stat.pool_empty)
                    begin
                        status_next = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_TAKE;
                end
                else if (is_pop)
                begin
                    if (stat.at_null)
                    begin
                        status_next = ST_EMPTY;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.op = OP_START_WALK;
                        state_next = S_WALK;
                    end
                end
                else if (req_reg == REQ_NONE)
                    state_next = S_OUT;
                else if (stat.head_null)
                begin
                    status_next = ST_EMPTY;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op = OP_START_WALK;
                    state_next = S_WALK;
                end
            S_WALK:
            begin
                cmd.op = OP_RD_CUR;
                state_next = S_CHECK;
            end
            S_READ:
            begin
                cmd.op = OP_RD_CUR;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op = OP_CHECK;
                if (is_pop)
                    state_next = S_UNLINK_P;
                else if (stat.match)
                begin
                    if (req_reg == REQ_REMOVE)
                        state_next = S_UNLINK_P;
                    else if (stat.pool_empty)
                    begin
                        status_next = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_TAKE;
                end
                else if (stat.walk_done)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next = S_OUT;
                end
                else
                    state_next = S_READ;
            end
            S_TAKE:
            begin
                cmd.op = OP_TAKE;
                state_next = S_LINK_NEW;
            end
            S_LINK_NEW:
            begin
                cmd.op = OP_LINK_NEW;
                state_next = S_LINK_P;
            end
            S_LINK_P:
            begin
                cmd.op = OP_LINK_P;
                state_next = S_LINK_Q;
            end
            S_LINK_Q:
            begin
                cmd.op = OP_LINK_Q;
                state_next = S_OUT;
            end
            S_UNLINK_P:
            begin
                cmd.op = OP_UNLINK_P;
                state_next = S_UNLINK_Q;
            end
            S_UNLINK_Q:
            begin
                cmd.op = OP_UNLINK_Q;
                state_next = S_GIVE;
            end
            S_GIVE:
            begin
                cmd.op = OP_GIVE;
                state_next = S_OUT;
            end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            status_reg <= ST_DONE;
            req_reg <= REQ_NONE;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
            if (state_reg == S_IDLE && in_valid)
                req_reg <= req_type;
        end
    end
endmodule
`default_nettype wire

### rtl/doubly_linked_list_manager_unit.sv
// Linked list manager: one request word in, one result word out.
// The input channel (in_valid/in_ready) carries req_type, data_value and search_key.
// The output channel (out_valid/out_ready) carries status, popped_value, list_empty.
// One request is handled at a time. A push takes a free slot, writes the new
// node and links its neighbours; a pop reads its end node, unlinks it and gives
// its slot back; a request that fails at once goes from dispatch to the result.
// Searching requests walk from the head, visiting at most CAPACITY nodes, each
// with one read through the single node memory read port and one compare.
// Once the result is taken, the unit returns to idle and then takes a new request.
// A result is held on the output until out_ready; no new request is taken
// while it waits.
// Reset empties the list and fills the free pool at once; no clearing pass.
// Depends on dll_pkg, dll_ctrl and dll_datapath.
`default_nettype none
module doubly_linked_list_manager_unit #(
    parameter int CAPACITY = 64,
    parameter int VALUE_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [2:0] req_type,
    input wire logic [31:0] data_value,
    input wire logic [31:0] search_key,
    output logic out_valid,
    input wire logic out_ready,
    output logic [1:0] status,
    output logic [31:0] popped_value,
    output logic list_empty
);
    import dll_pkg::*;

    cmd_t cmd;
    stat_t stat;

    dll_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .cmd(cmd), .stat(stat)
    );

    dll_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .req_type(req_type),
        .data_value(data_value), .search_key(search_key), .stat(stat),
        .popped_value(popped_value), .list_empty(list_empty)
    );

    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DONE) |-> popped_value == '0)
        else $error("popped value on failure");
    a_out_leave: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready) else $error("no return to idle");
endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the doubly linked list manager: directed and random requests checked
// word by word against an in-bench list predictor. Depends on dll_pkg and the unit.
`default_nettype none
module tb_top;
    import dll_pkg::*;

    localparam int CAP = 64;
    localparam int NIL = CAP;
    localparam int MAX_CYCLES = 1500000;

    typedef struct packed {
        status_t     st;
        logic [31:0] popped;
        logic        empty;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [31:0] data_value;
    logic [31:0] search_key;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] popped_value;
    logic        list_empty;

    logic [31:0] node_val [CAP];
    int          node_next [CAP];
    int          node_prev [CAP];
    int          head_slot;
    int          tail_slot;
    int          free_slots [CAP];
    int          free_num;

    result_t     expected_results [$];
    int          errors;
    int          checked;
    longint      cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    doubly_linked_list_manager_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .data_value(data_value), .search_key(search_key),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .popped_value(popped_value), .list_empty(list_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int find_slot(logic [31:0] v);
        int cur;
        int steps;
        cur = head_slot;
        steps = 0;
        while (cur != NIL && steps < CAP)
        begin
            if (node_val[cur] == v)
                return cur;
            cur = node_next[cur];
            steps++;
        end
        return NIL;
    endfunction

    function automatic void link_slot(int n, int p, int q);
        node_prev[n] = p;
        node_next[n] = q;
        if (p != NIL) node_next[p] = n; else head_slot = n;
        if (q != NIL) node_prev[q] = n; else tail_slot = p == NIL ? n : n;
        if (q == NIL) tail_slot = n;
    endfunction

    function automatic void unlink_slot(int n);
        int p;
        int q;
        p = node_prev[n];
        q = node_next[n];
        if (p != NIL) node_next[p] = q; else head_slot = q;
        if (q != NIL) node_prev[q] = p; else tail_slot = p;
        free_slots[free_num] = n;
        free_num++;
    endfunction

    function automatic result_t apply_request(req_t rq, logic [31:0] v, logic [31:0] k);
        result_t r;
        int n;
        int at;
        r.st = ST_DONE;
        r.popped = '0;
        case (rq)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (free_num == 0)
                    r.st = ST_FULL;
                else
                begin
                    free_num--;
                    n = free_slots[free_num];
                    node_val[n] = v;
                    if (rq == REQ_PUSH_FRONT) link_slot(n, NIL, head_slot);
                    else link_slot(n, tail_slot, NIL);
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                at = (rq == REQ_POP_FRONT) ? head_slot : tail_slot;
                if (at == NIL)
                    r.st = ST_EMPTY;
                else
                begin
                    r.popped = node_val[at];
                    unlink_slot(at);
                end
            end
            REQ_INS_AFTER, REQ_INS_BEFORE:
            begin
                if (head_slot == NIL)
                    r.st = ST_EMPTY;
                else
                begin
                    at = find_slot(k);
                    if (at == NIL)
                        r.st = ST_NOT_FOUND;
                    else if (free_num == 0)
                        r.st = ST_FULL;
                    else
                    begin
                        free_num--;
                        n = free_slots[free_num];
                        node_val[n] = v;
                        if (rq == REQ_INS_AFTER) link_slot(n, at, node_next[at]);
                        else link_slot(n, node_prev[at], at);
                    end
                end
            end
            REQ_REMOVE:
            begin
                if (head_slot == NIL)
                    r.st = ST_EMPTY;
                else
                begin
                    at = find_slot(v);
                    if (at == NIL) r.st = ST_NOT_FOUND;
                    else unlink_slot(at);
                end
            end
            default:
            begin
            end
        endcase
        r.empty = (head_slot == NIL);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on word %0d: %s got %0h want %0h", checked, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result word %0d", checked);
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (status !== e.st) report_mismatch("status", status, e.st);
                if (popped_value !== e.popped) report_mismatch("popped", popped_value, e.popped);
                if (list_empty !== e.empty) report_mismatch("empty", list_empty, e.empty);
            end
            checked++;
        end
    end

    initial
    begin
        wait (cycles >= MAX_CYCLES);
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_word(req_t rq, logic [31:0] v, logic [31:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        data_value <= v;
        search_key <= k;
        expected_results.push_back(apply_request(rq, v, k));
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [31:0] list_value();
        int cur;
        int hops;
        cur = head_slot;
        if (cur == NIL || $urandom_range(3) == 0)
            return $urandom_range(15);
        hops = $urandom_range(CAP - 1);
        while (hops > 0 && node_next[cur] != NIL)
        begin
            cur = node_next[cur];
            hops--;
        end
        return node_val[cur];
    endfunction

    task automatic test_directed();
        send_word(REQ_POP_FRONT, 0, 0);
        send_word(REQ_POP_BACK, 0, 0);
        send_word(REQ_INS_AFTER, 1, 1);
        send_word(REQ_INS_BEFORE, 1, 1);
        send_word(REQ_REMOVE, 1, 0);
        send_word(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(REQ_PUSH_FRONT, 32'h8000_0000, 0);
        send_word(REQ_PUSH_BACK, 32'h7FFF_FFFF, 0);
        send_word(REQ_INS_AFTER, 32'hFFFF_FFFF, 32'h8000_0000);
        send_word(REQ_INS_BEFORE, 0, 32'h7FFF_FFFF);
        send_word(REQ_INS_AFTER, 5, 32'h1234_5678);
        send_word(REQ_REMOVE, 32'h1234_5678, 0);
        send_word(REQ_REMOVE, 32'hFFFF_FFFF, 0);
        send_word(REQ_POP_FRONT, 0, 0);
        send_word(REQ_POP_BACK, 0, 0);
        send_word(REQ_POP_BACK, 0, 0);
        send_word(REQ_POP_BACK, 0, 0);
    endtask

    task automatic test_fill_and_drain();
        for (int i = 0; i < CAP + 2; i++)
            send_word(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom, 0);
        send_word(REQ_INS_AFTER, 7, list_value());
        send_word(REQ_INS_BEFORE, 7, 32'hDEAD_BEEF);
        for (int i = 0; i < CAP + 1; i++)
            send_word(i[0] ? REQ_POP_BACK : REQ_POP_FRONT, 0, 0);
    endtask

    task automatic test_random(int count);
        req_t rq;
        logic [31:0] v;
        for (int i = 0; i < count; i++)
        begin
            rq = req_t'($urandom_range(7));
            v = ($urandom_range(3) == 0) ? $urandom : list_value();
            if (rq == REQ_REMOVE || $urandom_range(1))
                send_word(rq, v, list_value());
            else
                send_word(rq, $urandom, list_value());
        end
    endtask

    task automatic test_idling();
        send_idle_pct = 62;
        recv_stall_pct = 0;
        test_random(450);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        test_random(450);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        test_random(450);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        data_value = '0;
        search_key = '0;
        out_ready = 1'b0;
        errors = 0;
        checked = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        head_slot = NIL;
        tail_slot = NIL;
        free_num = CAP;
        for (int i = 0; i < CAP; i++)
            free_slots[i] = CAP - 1 - i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_drain();
        test_random(450);
        test_idling();
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * CAP + 20) @(posedge clk);
        $display("Checked %0d result words from directed, fill and drain, and random", checked);
        $display("requests under four idling mixes; %0d mismatches.", errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
